### hw/rtl/cbt_pkg.sv
// Shared types, constants and helpers for the cubic Bezier tessellator.
// Used by cbt_controller, cbt_datapath and cubic_bezier_tessellator_unit.
package cbt_pkg;

   localparam int COORD_WIDTH     = 24;
   localparam int COUNT_WIDTH     = 6;
   localparam int MAX_SEGMENTS    = 63;
   localparam int DEF_T_FRAC_BITS = 16;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] start_x;
      logic signed [COORD_WIDTH-1:0] start_y;
      logic signed [COORD_WIDTH-1:0] ctrl_a_x;
      logic signed [COORD_WIDTH-1:0] ctrl_a_y;
      logic signed [COORD_WIDTH-1:0] ctrl_b_x;
      logic signed [COORD_WIDTH-1:0] ctrl_b_y;
      logic signed [COORD_WIDTH-1:0] end_x;
      logic signed [COORD_WIDTH-1:0] end_y;
      logic [COUNT_WIDTH-1:0]        segment_count;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] vertex_x;
      logic signed [COORD_WIDTH-1:0] vertex_y;
      logic [COUNT_WIDTH-1:0]        vertex_index;
      logic                          last_vertex;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                   load;
      logic                   div_step;
      logic                   issue;
      logic                   last;
      logic [COUNT_WIDTH-1:0] index;
      logic [COUNT_WIDTH-1:0] count;
   } cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic advance;
      logic empty;
   } status_type;

   // Segment counts above the supported maximum are clamped to it.
   function automatic logic [COUNT_WIDTH-1:0] saturate_count(input logic [COUNT_WIDTH-1:0] n);
      if (32'(n) > MAX_SEGMENTS) begin
         return COUNT_WIDTH'(MAX_SEGMENTS);
      end
      return n;
   endfunction

endpackage

### hw/rtl/cbt_controller.sv
// Sequencing state machine of the tessellator: divide, issue vertices, drain.
// Depends on cbt_pkg for the command and status structs.
module cbt_controller #(
   parameter int T_FRAC_BITS = cbt_pkg::DEF_T_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_accept,
   input  logic [cbt_pkg::COUNT_WIDTH-1:0] req_count,
   input  cbt_pkg::status_type            status,
   output cbt_pkg::cmd_type               cmd,
   output logic                           req_stall
);
   import cbt_pkg::*;

   localparam int DIV_STEPS = T_FRAC_BITS + 1;
   localparam int DCW       = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   state_type              state_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] index_ff;
   logic [DCW-1:0]         div_cnt_ff;
   logic                   stall_ff;
   logic [COUNT_WIDTH-1:0] count_in;

   assign count_in  = saturate_count(req_count);
   assign req_stall = stall_ff;

   always_comb begin
      cmd.load     = req_accept;
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.issue    = (state_ff == ST_ISSUE) && status.advance;
      cmd.last     = (index_ff == count_ff);
      cmd.index    = index_ff;
      cmd.count    = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         stall_ff   <= 1'b1;
         count_ff   <= '0;
         index_ff   <= '0;
         div_cnt_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               stall_ff <= req_accept;
               if (req_accept) begin
                  count_ff   <= count_in;
                  index_ff   <= '0;
                  div_cnt_ff <= '0;
                  // With no segments only the end point goes out, so no step is needed.
                  state_ff   <= (count_in == '0) ? ST_ISSUE : ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (div_cnt_ff == DCW'(DIV_STEPS - 1)) begin
                  state_ff <= ST_ISSUE;
               end else begin
                  div_cnt_ff <= div_cnt_ff + 1'b1;
               end
            end
            ST_ISSUE: begin
               if (status.advance) begin
                  if (index_ff == count_ff) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     index_ff <= index_ff + 1'b1;
                  end
               end
            end
            ST_DRAIN: begin
               if (status.empty) begin
                  state_ff <= ST_IDLE;
                  stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### hw/rtl/cbt_datapath.sv
// Datapath of the tessellator: step divider, parameter stepper and the
// vertex evaluation pipeline with its output register. Depends on cbt_pkg.
module cbt_datapath #(
   parameter int T_FRAC_BITS = cbt_pkg::DEF_T_FRAC_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  cbt_pkg::req_type    req_data,
   input  cbt_pkg::cmd_type    cmd,
   output cbt_pkg::status_type status,
   output logic                rsp_valid,
   output cbt_pkg::rsp_type    rsp_data,
   input  logic                rsp_stall
);
   import cbt_pkg::*;

   localparam int TW = T_FRAC_BITS + 1;          // t, u and the rounded squares
   localparam int WW = T_FRAC_BITS + 2;          // weights, up to three times one
   localparam int PW = WW + 1 + COORD_WIDTH;     // weight times coordinate
   localparam int AW = PW + 1;                   // pair sums
   localparam int SW = PW + 2;                   // full sum with rounding bias

   localparam logic [TW-1:0]          T_ONE      = {1'b1, {T_FRAC_BITS{1'b0}}};
   localparam logic [2*TW-1:0]        HALF_P     = (2*TW)'(1) << (T_FRAC_BITS - 1);
   localparam logic signed [SW-1:0]   ROUND_BIAS = SW'(1) << (T_FRAC_BITS - 1);
   localparam logic signed [SW-1:0]   COORD_MAX_S = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
   localparam logic signed [SW-1:0]   COORD_MIN_S = -COORD_MAX_S - SW'(1);

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] index;
      logic                   last;
   } tag_type;

   function automatic logic [TW-1:0] rmul(input logic [TW-1:0] a, input logic [TW-1:0] b);
      logic [2*TW-1:0] p;
      p = a * b + HALF_P;
      return p[T_FRAC_BITS +: TW];
   endfunction

   function automatic logic [WW-1:0] times3(input logic [TW-1:0] x);
      return {1'b0, x} + {x, 1'b0};
   endfunction

   function automatic logic [COORD_WIDTH-1:0] clamp(input logic signed [SW-1:0] v);
      if (v > COORD_MAX_S) begin
         return COORD_MAX_S[COORD_WIDTH-1:0];
      end else if (v < COORD_MIN_S) begin
         return COORD_MIN_S[COORD_WIDTH-1:0];
      end
      return v[COORD_WIDTH-1:0];
   endfunction

   // Held curve, in input field order.
   logic signed [COORD_WIDTH-1:0] pts_ff [8];

   // Restoring divider for 2^F / N, and the exact stepper for t = i/N.
   logic [COUNT_WIDTH-1:0] div_rem_ff;
   logic [TW-1:0]          div_quo_ff;
   logic [COUNT_WIDTH:0]   div_shift;
   logic [TW-1:0]          step_q_ff;
   logic [COUNT_WIDTH-1:0] step_r_ff;
   logic [COUNT_WIDTH:0]   step_sum;

   // Pipeline.
   logic                          advance;
   logic                          v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   tag_type                       tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff;
   logic [TW-1:0]                 t1_ff, u1_ff, t2_ff, u2_ff, uu2_ff, tt2_ff;
   logic [WW-1:0]                 w3_ff [4];
   logic signed [PW-1:0]          px4_ff [4];
   logic signed [PW-1:0]          py4_ff [4];
   logic signed [AW-1:0]          ax5_ff, bx5_ff, ay5_ff, by5_ff;
   logic signed [SW-1:0]          sum_x, sum_y, shr_x, shr_y;
   logic                          rsp_valid_ff;
   rsp_type                       rsp_ff;

   assign advance       = !rsp_valid_ff || !rsp_stall;
   assign status.advance = advance;
   assign status.empty  = !(v1_ff || v2_ff || v3_ff || v4_ff || v5_ff || rsp_valid_ff);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

   assign div_shift = {div_rem_ff, div_quo_ff[TW-1]};
   assign step_sum  = {1'b0, step_r_ff} + {1'b0, div_rem_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pts_ff[0]  <= req_data.start_x;
         pts_ff[1]  <= req_data.start_y;
         pts_ff[2]  <= req_data.ctrl_a_x;
         pts_ff[3]  <= req_data.ctrl_a_y;
         pts_ff[4]  <= req_data.ctrl_b_x;
         pts_ff[5]  <= req_data.ctrl_b_y;
         pts_ff[6]  <= req_data.end_x;
         pts_ff[7]  <= req_data.end_y;
         div_rem_ff <= '0;
         div_quo_ff <= T_ONE;
      end else if (cmd.div_step) begin
         if (div_shift >= {1'b0, cmd.count}) begin
            div_rem_ff <= COUNT_WIDTH'(div_shift - {1'b0, cmd.count});
            div_quo_ff <= {div_quo_ff[TW-2:0], 1'b1};
         end else begin
            div_rem_ff <= div_shift[COUNT_WIDTH-1:0];
            div_quo_ff <= {div_quo_ff[TW-2:0], 1'b0};
         end
      end
   end

   // Numerator i*2^F + N/2 is tracked as quotient and remainder by N.
   always_ff @(posedge clock) begin
      if (cmd.div_step) begin
         step_q_ff <= '0;
         step_r_ff <= cmd.count >> 1;
      end else if (cmd.issue && !cmd.last) begin
         if (step_sum >= {1'b0, cmd.count}) begin
            step_r_ff <= COUNT_WIDTH'(step_sum - {1'b0, cmd.count});
            step_q_ff <= step_q_ff + div_quo_ff + 1'b1;
         end else begin
            step_r_ff <= step_sum[COUNT_WIDTH-1:0];
            step_q_ff <= step_q_ff + div_quo_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= cmd.issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         rsp_valid_ff <= v5_ff;
      end
   end

   always_comb begin
      sum_x = ax5_ff + bx5_ff + ROUND_BIAS;
      sum_y = ay5_ff + by5_ff + ROUND_BIAS;
      shr_x = sum_x >>> T_FRAC_BITS;
      shr_y = sum_y >>> T_FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // Parameter values.
         t1_ff   <= step_q_ff;
         u1_ff   <= T_ONE - step_q_ff;
         tag1_ff <= '{index: cmd.index, last: cmd.last};
         // Squares.
         t2_ff   <= t1_ff;
         u2_ff   <= u1_ff;
         uu2_ff  <= rmul(u1_ff, u1_ff);
         tt2_ff  <= rmul(t1_ff, t1_ff);
         tag2_ff <= tag1_ff;
         // Bernstein weights.
         w3_ff[0] <= {1'b0, rmul(uu2_ff, u2_ff)};
         w3_ff[1] <= times3(rmul(uu2_ff, t2_ff));
         w3_ff[2] <= times3(rmul(tt2_ff, u2_ff));
         w3_ff[3] <= {1'b0, rmul(tt2_ff, t2_ff)};
         tag3_ff  <= tag2_ff;
         // Weighted coordinates, one multiplier per term and axis.
         for (int k = 0; k < 4; k++) begin
            px4_ff[k] <= $signed({1'b0, w3_ff[k]}) * pts_ff[2*k];
            py4_ff[k] <= $signed({1'b0, w3_ff[k]}) * pts_ff[2*k+1];
         end
         tag4_ff <= tag3_ff;
         // Pair sums.
         ax5_ff  <= px4_ff[0] + px4_ff[1];
         bx5_ff  <= px4_ff[2] + px4_ff[3];
         ay5_ff  <= py4_ff[0] + py4_ff[1];
         by5_ff  <= py4_ff[2] + py4_ff[3];
         tag5_ff <= tag4_ff;
         // Final sum, rounding and clamp; the closing vertex is the end point itself.
         if (tag5_ff.last) begin
            rsp_ff.vertex_x <= pts_ff[6];
            rsp_ff.vertex_y <= pts_ff[7];
         end else begin
            rsp_ff.vertex_x <= clamp(shr_x);
            rsp_ff.vertex_y <= clamp(shr_y);
         end
         rsp_ff.vertex_index <= tag5_ff.index;
         rsp_ff.last_vertex  <= tag5_ff.last;
      end
   end

endmodule

### hw/rtl/cubic_bezier_tessellator_unit.sv
// Cubic Bezier tessellator top level; uses cbt_pkg, cbt_controller and cbt_datapath.
// It takes one curve at a time: unless N is zero a bit-serial divider runs first, then
// one vertex a cycle is issued while the output is not stalled, and the next curve is
// taken only once the six-stage vertex pipeline has drained. Reset is synchronous and
// active high; it empties the pipeline and returns the controller to idle.
module cubic_bezier_tessellator_unit #(
   parameter int T_FRAC_BITS = cbt_pkg::DEF_T_FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cbt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cbt_pkg::rsp_type rsp_data
);
   import cbt_pkg::*;

   // An item is taken at any edge where valid is high and the block is not stalling.
   // The block takes one curve at a time and stalls until its last vertex has left.
   logic       req_accept;
   cmd_type    cmd;
   status_type status;

   assign req_accept = req_valid && !req_stall;

   // The controller has up to three phases per curve. Unless N is zero, it first
   // runs the divider that forms 2^F / N as quotient and remainder, one bit per cycle.
   // It then issues one vertex index per cycle whenever the pipeline can move,
   // and the final index N carries the last flag. Finally it waits until every
   // vertex has left the output register before it takes the next item.
   cbt_controller #(
      .T_FRAC_BITS(T_FRAC_BITS)
   ) u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_count  (req_data.segment_count),
      .status     (status),
      .cmd        (cmd),
      .req_stall  (req_stall)
   );

   // The datapath steps t = i/N exactly by adding quotient and remainder, then
   // evaluates the Bernstein weights and the weighted sum in five registered
   // stages ahead of the output register. The whole pipeline holds while a
   // finished vertex is waiting to be taken.
   cbt_datapath #(
      .T_FRAC_BITS(T_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule
